// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; expects clk and rst_n in scope at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define EFWS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define EFWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/efws_pkg.sv =====
// Shared constants, key and control types and compare function for the scheduler.
// No dependencies.
package efws_pkg;

  localparam int unsigned MAX_WORKERS = 64;
  localparam int unsigned TIME_BITS   = 48;
  localparam int unsigned IDX_BITS    = $clog2(MAX_WORKERS);
  localparam int unsigned DUR_BITS    = 32;
  localparam int unsigned CNT_BITS    = 7;

  localparam int unsigned RST_COUNT   = 64;
  localparam int unsigned RST_LIVE_I  = (RST_COUNT == 0) ? 1 :
                                        (RST_COUNT > MAX_WORKERS) ? MAX_WORKERS :
                                        RST_COUNT;
  localparam logic [IDX_BITS:0] RST_LIVE = (IDX_BITS + 1)'(RST_LIVE_I);

  typedef struct packed {
    logic [TIME_BITS-1:0] tm;
    logic [IDX_BITS-1:0]  idx;
  } efws_key_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } efws_ctl_t;

  function automatic logic key_lt(input efws_key_t a, input efws_key_t b);
    key_lt = (a < b);
  endfunction

endpackage

// ===== src/efws_cell.sv =====
// One slot of the sorted worker chain: holds a (free time, worker) key.
// Depends on efws_pkg.
module efws_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  efws_pkg::efws_ctl_t              ctl,
  input  efws_pkg::efws_key_t              ins_key,
  input  efws_pkg::efws_key_t              nb_key,
  input  logic                             nb_valid,
  input  logic [efws_pkg::IDX_BITS-1:0]    home_idx,
  input  logic                             home_live,
  input  logic                             first,
  output efws_pkg::efws_key_t              key,
  output logic                             valid
);

  efws_pkg::efws_key_t key_r, key_nxt;
  logic                valid_r, valid_nxt;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctl.clear) begin
      key_nxt.tm  = '0;
      key_nxt.idx = home_idx;
      valid_nxt   = home_live;
    end else if (ctl.shift && valid_r) begin
      if (nb_valid && efws_pkg::key_lt(nb_key, ins_key)) begin
        key_nxt = nb_key;
      end else if (first || efws_pkg::key_lt(key_r, ins_key)) begin
        key_nxt = ins_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r.tm  <= '0;
      key_r.idx <= home_idx;
      valid_r   <= ({1'b0, home_idx} < efws_pkg::RST_LIVE);
    end else begin
      key_r   <= key_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign key   = key_r;
  assign valid = valid_r;

endmodule

// ===== src/earliest_free_worker_scheduler_top.sv =====
// Earliest-free worker scheduler, top level: sorted cell chain plus output word register.
// Depends on efws_pkg and efws_cell.
//
// For each job, the head cell of a chain of MAX_WORKERS cells, kept sorted
// by (free time, worker), gives the chosen worker and start time; the saturated new free
// time is broadcast to every cell, which in the same cycle either takes its neighbor's
// key, the new key, or holds. One job is accepted per cycle as long as the result word
// is taken; the critical path is the 48-bit saturating add followed by the per-cell
// key compare. A write of worker_count clears all free times and is always
// ready; write it only while no job is in flight. A count of zero acts as one, a count
// above MAX_WORKERS as MAX_WORKERS.
module earliest_free_worker_scheduler_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [efws_pkg::DUR_BITS-1:0]    in_job_duration,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [efws_pkg::IDX_BITS-1:0]    out_worker_index,
  output logic [efws_pkg::TIME_BITS-1:0]   out_start_time,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [efws_pkg::CNT_BITS-1:0]    cfg_worker_count
);

  efws_pkg::efws_key_t key   [efws_pkg::MAX_WORKERS+1];
  logic                kvld  [efws_pkg::MAX_WORKERS+1];
  efws_pkg::efws_key_t ins_key;
  efws_pkg::efws_ctl_t ctl;
  logic                acc;
  logic [efws_pkg::TIME_BITS:0]   sum;
  logic [31:0]                    cnt_ext;
  logic [31:0]                    cnt_eff;

  logic                           out_valid_r, out_valid_nxt;
  logic [efws_pkg::IDX_BITS-1:0]  out_idx_r;
  logic [efws_pkg::TIME_BITS-1:0] out_tm_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign acc       = in_valid && !in_stall;

  assign ctl.shift = acc;
  assign ctl.clear = cfg_valid;

  assign cnt_ext = 32'(cfg_worker_count);
  assign cnt_eff = (cnt_ext == 32'd0) ? 32'd1 :
                   (cnt_ext > 32'(efws_pkg::MAX_WORKERS)) ? 32'(efws_pkg::MAX_WORKERS) :
                   cnt_ext;

  assign sum = {1'b0, key[0].tm} + (efws_pkg::TIME_BITS + 1)'(in_job_duration);
  assign ins_key.tm  = sum[efws_pkg::TIME_BITS] ? '1 : sum[efws_pkg::TIME_BITS-1:0];
  assign ins_key.idx = key[0].idx;

  assign key[efws_pkg::MAX_WORKERS]  = '0;
  assign kvld[efws_pkg::MAX_WORKERS] = 1'b0;

  for (genvar k = 0; k < efws_pkg::MAX_WORKERS; k++) begin : g_cell
    efws_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .ins_key   (ins_key),
      .nb_key    (key[k+1]),
      .nb_valid  (kvld[k+1]),
      .home_idx  (efws_pkg::IDX_BITS'(k)),
      .home_live (32'(k) < cnt_eff),
      .first     (k == 0),
      .key       (key[k]),
      .valid     (kvld[k])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_idx_r <= key[0].idx;
      out_tm_r  <= key[0].tm;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_worker_index = out_idx_r;
  assign out_start_time   = out_tm_r;

endmodule

// ===== src/efws_checker.sv =====
// Port-level checks for the scheduler top, attached by bind.
// Depends on efws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module efws_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [efws_pkg::IDX_BITS-1:0]    out_worker_index,
  input logic [efws_pkg::TIME_BITS-1:0]   out_start_time
);

  `EFWS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, $stable(out_worker_index) && $stable(out_start_time), "stalled result word changed")
  `EFWS_ASSERT_NEXT(a_acc_out, in_valid && !in_stall, out_valid, "accepted job gave no result word")
  `EFWS_ASSERT_SAME(a_stall_full, out_valid && out_stall, in_stall, "job taken while result word is stalled")
  `EFWS_ASSERT_SAME(a_stall_empty, !out_valid, !in_stall, "input stalled with output register empty")

endmodule

bind earliest_free_worker_scheduler_top efws_checker u_efws_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_worker_index (out_worker_index),
  .out_start_time   (out_start_time)
);
